[sv/cpop_pkg.sv]
// ============================================================================
// Closest pair of points: shared types
// Beat formats of the point and result channels, and the fixed field widths.
// ============================================================================
package cpop_pkg;

    localparam int FIELD_W = 16;
    localparam int DIST_W  = 33;
    localparam int ROOT_W  = 17;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic                      last_point;
    } point_in_t;

    typedef struct packed {
        logic                      pair_found;
        logic [DIST_W-1:0]         dist_squared;
        logic [ROOT_W-1:0]         distance_floor;
        logic signed [FIELD_W-1:0] first_x;
        logic signed [FIELD_W-1:0] first_y;
        logic signed [FIELD_W-1:0] second_x;
        logic signed [FIELD_W-1:0] second_y;
        logic                      points_dropped;
    } pair_out_t;

endpackage

[sv/closest_pair_of_points.sv]
// ============================================================================
// Closest pair of points
// Loads a set of points into a store, then searches all pairs for the closest.
// ============================================================================
// Points arrive as beats on the pt channel (pt_valid, pt_ready, pt_data); the
// beat with last_point set closes the set. Each point beat is written to the
// point store at the next free entry; points beyond MAX_POINTS are dropped and
// flagged. After the closing beat the block checks every pair in load order,
// reading one stored point per cycle from the single read port of the store,
// then empties the distance pipeline, takes a bit-serial square root of the
// best squared distance and finishes. One result beat then appears on the res
// channel (res_valid, res_ready, res_data). The pt channel accepts no beat
// during the search. If the receiver stalls, the result is held in the output
// register; the next set can be loaded meanwhile, and its own result waits
// until the previous one has been taken. Reset empties the set and drops any
// pending result; the store contents are not cleared, since only entries
// written in the current set are ever read.
// ============================================================================
module closest_pair_of_points
    import cpop_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pt_valid,
    output logic      pt_ready,
    input  point_in_t pt_data,
    output logic      res_valid,
    input  logic      res_ready,
    output pair_out_t res_data
);

    localparam int SW  = (COORD_BITS > FIELD_W) ? FIELD_W + 1 : COORD_BITS;
    localparam int DW  = 2 * SW + 1;
    localparam int SQW = (DW + 1) / 2;
    localparam int SQ2 = 2 * SQW;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDI   = 3'd1;
    localparam logic [2:0] S_LDI   = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    function automatic logic [SW-1:0] coord_in(input logic [FIELD_W-1:0] f);
        logic [SW-1:0] v;
        if (COORD_BITS > FIELD_W)
            v = SW'(f);
        else
            v = SW'($signed(f));
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] coord_out(input logic [SW-1:0] v);
        return FIELD_W'($signed(v));
    endfunction

    function automatic logic [SW-1:0] abs_diff(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        logic signed [SW:0] d;
        d = $signed({a[SW-1], a}) - $signed({b[SW-1], b});
        return SW'(d[SW] ? (~d + 1'b1) : d);
    endfunction

    logic [2*SW-1:0] mem [MAX_POINTS];

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg;
    logic            ovf_reg;
    logic [AW-1:0]   i_reg, j_reg, last_reg;
    logic [2*SW-1:0] rd_data_reg, pi_reg;
    logic            rd_vld_reg, v1_reg, v2_reg, v3_reg;
    logic [SW-1:0]   dx1_reg, dy1_reg;
    logic [2*SW-1:0] pa1_reg, pb1_reg, pa2_reg, pb2_reg, pa3_reg, pb3_reg;
    logic [2*SW-1:0] sqx2_reg, sqy2_reg;
    logic [DW-1:0]   sum3_reg, best_reg;
    logic            found_reg;
    logic [2*SW-1:0] bpa_reg, bpb_reg;
    logic [SQ2-1:0]  sqn_reg, sqr_reg, bit_reg;
    logic            res_valid_reg;
    pair_out_t       res_reg;

    logic            accept, stored, row_end, search_end, drained, fin_go;
    logic            wr_en, rd_en, rd_pair;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   cnt_fin;
    logic [2*SW-1:0] wr_data;
    logic [2*SW-1:0] sqx, sqy;
    logic [SQ2:0]    trial;

    assign pt_ready   = (state_reg == S_IDLE);
    assign accept     = pt_valid && pt_ready;
    assign stored     = (count_reg < CW'(MAX_POINTS));
    assign cnt_fin    = stored ? CW'(count_reg + 1'b1) : count_reg;
    assign row_end    = (j_reg == last_reg);
    assign search_end = (AW'(i_reg + 1'b1) == last_reg);
    assign drained    = !rd_vld_reg && !v1_reg && !v2_reg && !v3_reg;
    assign fin_go     = !res_valid_reg || res_ready;
    assign wr_data    = {coord_in(pt_data.point_x), coord_in(pt_data.point_y)};
    assign sqx        = dx1_reg * dx1_reg;
    assign sqy        = dy1_reg * dy1_reg;
    assign trial      = {1'b0, sqr_reg} + {1'b0, bit_reg};
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;

    always_comb
    begin
        state_next = state_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_pair    = 1'b0;
        rd_addr    = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                wr_en = accept && stored;
                if (accept && pt_data.last_point)
                    state_next = (cnt_fin < CW'(2)) ? S_FIN : S_RDI;
            end
            S_RDI:
            begin
                rd_en      = 1'b1;
                state_next = S_LDI;
            end
            S_LDI, S_SWEEP:
            begin
                rd_en   = 1'b1;
                rd_pair = 1'b1;
                rd_addr = j_reg;
                if (row_end)
                    state_next = search_end ? S_DRAIN : S_RDI;
                else
                    state_next = S_SWEEP;
            end
            S_DRAIN:
            begin
                if (drained)
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (bit_reg[0])
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Writes happen only while loading and reads only while searching, so
    // the two ports never touch the store in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_vld_reg    <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en && rd_pair;
            v1_reg     <= rd_vld_reg;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            if (accept)
            begin
                if (stored)
                    count_reg <= CW'(count_reg + 1'b1);
                else
                    ovf_reg <= 1'b1;
            end
            if (state_reg == S_FIN && fin_go)
            begin
                count_reg     <= '0;
                ovf_reg       <= 1'b0;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg  <= abs_diff(pi_reg[2*SW-1:SW], rd_data_reg[2*SW-1:SW]);
        dy1_reg  <= abs_diff(pi_reg[SW-1:0], rd_data_reg[SW-1:0]);
        pa1_reg  <= pi_reg;
        pb1_reg  <= rd_data_reg;
        sqx2_reg <= sqx;
        sqy2_reg <= sqy;
        pa2_reg  <= pa1_reg;
        pb2_reg  <= pb1_reg;
        sum3_reg <= {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        pa3_reg  <= pa2_reg;
        pb3_reg  <= pb2_reg;

        if (v3_reg && (!found_reg || sum3_reg < best_reg))
        begin
            found_reg <= 1'b1;
            best_reg  <= sum3_reg;
            bpa_reg   <= pa3_reg;
            bpb_reg   <= pb3_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && pt_data.last_point)
                begin
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                    bpa_reg   <= '0;
                    bpb_reg   <= '0;
                    sqn_reg   <= '0;
                    sqr_reg   <= '0;
                    i_reg     <= '0;
                    last_reg  <= AW'(cnt_fin - 1'b1);
                end
            end
            S_RDI:
            begin
                j_reg <= AW'(i_reg + 1'b1);
            end
            S_LDI, S_SWEEP:
            begin
                if (state_reg == S_LDI)
                    pi_reg <= rd_data_reg;
                j_reg <= AW'(j_reg + 1'b1);
                if (row_end && !search_end)
                    i_reg <= AW'(i_reg + 1'b1);
            end
            S_DRAIN:
            begin
                if (drained)
                begin
                    sqn_reg <= SQ2'(best_reg);
                    sqr_reg <= '0;
                    bit_reg <= SQ2'(1) << (SQ2 - 2);
                end
            end
            S_SQRT:
            begin
                if ({1'b0, sqn_reg} >= trial)
                begin
                    sqn_reg <= SQ2'({1'b0, sqn_reg} - trial);
                    sqr_reg <= (sqr_reg >> 1) + bit_reg;
                end
                else
                begin
                    sqr_reg <= sqr_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    res_reg.pair_found     <= found_reg;
                    res_reg.dist_squared   <= DIST_W'(best_reg);
                    res_reg.distance_floor <= ROOT_W'(sqr_reg);
                    res_reg.first_x        <= coord_out(bpa_reg[2*SW-1:SW]);
                    res_reg.first_y        <= coord_out(bpa_reg[SW-1:0]);
                    res_reg.second_x       <= coord_out(bpb_reg[2*SW-1:SW]);
                    res_reg.second_y       <= coord_out(bpb_reg[SW-1:0]);
                    res_reg.points_dropped <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("store written and read in the same cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store size");

    a_drained_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (!v3_reg && !rd_vld_reg))
        else $error("square root started with pairs still in flight");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result beat raised outside the finish step");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && fin_go) |=> (count_reg == '0 && !ovf_reg))
        else $error("set not emptied after its result");

endmodule
